// ===== rtl/hcf_pkg.sv =====
// ----------------------------------------------------------------------------
// hcf_pkg: shared types and saturating arithmetic
// Word format, configuration layout and clipping helpers for the contact core.
// ----------------------------------------------------------------------------
package hcf_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 3;
    localparam int PROD_W = 2 * WORD_W;
    localparam int DIV_W  = WORD_W + FRAC_W;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    localparam logic [IDX_W-1:0] CFG_LOADING_STIFFNESS     = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_LIMIT_STIFFNESS       = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_ADHESION_STIFFNESS    = IDX_W'(2);
    localparam logic [IDX_W-1:0] CFG_DAMPING_COEFFICIENT   = IDX_W'(3);
    localparam logic [IDX_W-1:0] CFG_PLASTIC_LIMIT_OVERLAP = IDX_W'(4);
    localparam logic [IDX_W-1:0] CFG_PLASTIC_OVERLAP_CAP   = IDX_W'(5);

    localparam logic [CFG_W-1:0] RST_LOADING_STIFFNESS     = CFG_W'(65536);
    localparam logic [CFG_W-1:0] RST_LIMIT_STIFFNESS       = CFG_W'(131072);
    localparam logic [CFG_W-1:0] RST_ADHESION_STIFFNESS    = CFG_W'(0);
    localparam logic [CFG_W-1:0] RST_DAMPING_COEFFICIENT   = CFG_W'(0);
    localparam logic [CFG_W-1:0] RST_PLASTIC_LIMIT_OVERLAP = CFG_W'(65536);
    localparam logic [CFG_W-1:0] RST_PLASTIC_OVERLAP_CAP   = CFG_W'(65536);

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic  sat;
        t_word val;
    } t_sv;

    typedef struct packed {
        t_word overlap;
        t_word normal_velocity;
        logic  new_contact;
        logic  neg;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] k1;
        logic [CFG_W-1:0] kp;
        logic [CFG_W-1:0] kc;
        logic [CFG_W-1:0] g0;
        logic [CFG_W-1:0] dpm;
        logic [CFG_W-1:0] dpn;
    } t_cfg;

    function automatic logic [WORD_W-1:0] f_mag(input t_word a);
        logic [WORD_W-1:0] r;
        r = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
        return r;
    endfunction

    function automatic t_sv f_clip(input logic neg, input logic [DIV_W-1:0] m);
        t_sv r;
        logic [DIV_W-1:0] lim;
        lim = DIV_W'(Q_MAX);
        if (!neg) begin
            if (m > lim) begin
                r.sat = 1'b1;
                r.val = Q_MAX;
            end else begin
                r.sat = 1'b0;
                r.val = t_word'(m[WORD_W-1:0]);
            end
        end else begin
            if (m > lim) begin
                r.sat = (m != lim + DIV_W'(1));
                r.val = Q_MIN;
            end else begin
                r.sat = 1'b0;
                r.val = t_word'(0) - t_word'(m[WORD_W-1:0]);
            end
        end
        return r;
    endfunction

    function automatic t_sv f_add(input t_word a, input t_word b);
        t_sv r;
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        r.sat = (s[WORD_W] != s[WORD_W-1]);
        r.val = r.sat ? (s[WORD_W] ? Q_MIN : Q_MAX) : t_word'(s[WORD_W-1:0]);
        return r;
    endfunction

    function automatic t_sv f_sub(input t_word a, input t_word b);
        t_sv r;
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        r.sat = (s[WORD_W] != s[WORD_W-1]);
        r.val = r.sat ? (s[WORD_W] ? Q_MIN : Q_MAX) : t_word'(s[WORD_W-1:0]);
        return r;
    endfunction

    function automatic t_word f_ext(input logic [CFG_W-1:0] k);
        return t_word'({1'b0, k});
    endfunction

endpackage

// ===== rtl/hcf_in_if.sv =====
// ----------------------------------------------------------------------------
// hcf_in_if: input item channel
// Valid/ready channel carrying overlap, normal velocity and new-contact flag.
// ----------------------------------------------------------------------------
interface hcf_in_if;
    logic                 valid;
    logic                 ready;
    hcf_pkg::t_word       overlap;
    hcf_pkg::t_word       normal_velocity;
    logic                 new_contact;

    modport source (output valid, output overlap, output normal_velocity,
                    output new_contact, input ready);
    modport sink   (input valid, input overlap, input normal_velocity,
                    input new_contact, output ready);
endinterface

// ===== rtl/hcf_out_if.sv =====
// ----------------------------------------------------------------------------
// hcf_out_if: result item channel
// Valid/ready channel carrying contact flag, normal force and clip flag.
// ----------------------------------------------------------------------------
interface hcf_out_if;
    logic                 valid;
    logic                 ready;
    logic                 in_contact;
    hcf_pkg::t_word       normal_force;
    logic                 saturated;

    modport source (output valid, output in_contact, output normal_force,
                    output saturated, input ready);
    modport sink   (input valid, input in_contact, input normal_force,
                    input saturated, output ready);
endinterface

// ===== rtl/hcf_front.sv =====
// ----------------------------------------------------------------------------
// hcf_front: intake and item queue
// Accepts items, flags negative overlap and holds them in a short queue.
// ----------------------------------------------------------------------------
module hcf_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hcf_pkg::t_item i_item,
    output logic           o_valid,
    output hcf_pkg::t_item o_item,
    input  logic           i_take
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hcf_pkg::t_item   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    hcf_pkg::t_item   push_item;
    logic             push, pop;

    assign o_ready = (r_count < CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_take && o_valid;

    always_comb begin
        push_item     = i_item;
        push_item.neg = i_item.overlap[hcf_pkg::WORD_W-1];
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        o_item <= r_mem[n_rd_ptr];
        if (push && (n_rd_ptr == r_wr_ptr)) begin
            o_item <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end
endmodule

// ===== rtl/hcf_back.sv =====
// ----------------------------------------------------------------------------
// hcf_back: force sequencer
// Runs the contact law on one item at a time with a shared multiplier and a
// radix-2 divider, keeps the contact history and holds the result register.
// ----------------------------------------------------------------------------
module hcf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hcf_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    input  hcf_pkg::t_item        i_item,
    output logic                  o_take,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_in_contact,
    output hcf_pkg::t_word        o_normal_force,
    output logic                  o_saturated
);
    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_IDLE   = 5'd0;
    localparam logic [ST_W-1:0] ST_CHK    = 5'd1;
    localparam logic [ST_W-1:0] ST_K2B    = 5'd2;
    localparam logic [ST_W-1:0] ST_K2C    = 5'd3;
    localparam logic [ST_W-1:0] ST_K2D    = 5'd4;
    localparam logic [ST_W-1:0] ST_NEWMAX = 5'd5;
    localparam logic [ST_W-1:0] ST_PN0    = 5'd6;
    localparam logic [ST_W-1:0] ST_PN1    = 5'd7;
    localparam logic [ST_W-1:0] ST_PN2    = 5'd8;
    localparam logic [ST_W-1:0] ST_T0     = 5'd9;
    localparam logic [ST_W-1:0] ST_T1     = 5'd10;
    localparam logic [ST_W-1:0] ST_T2     = 5'd11;
    localparam logic [ST_W-1:0] ST_T3     = 5'd12;
    localparam logic [ST_W-1:0] ST_BR     = 5'd13;
    localparam logic [ST_W-1:0] ST_AD1    = 5'd14;
    localparam logic [ST_W-1:0] ST_AD2    = 5'd15;
    localparam logic [ST_W-1:0] ST_FIN    = 5'd16;
    localparam logic [ST_W-1:0] ST_OUT    = 5'd17;
    localparam logic [ST_W-1:0] ST_NEG    = 5'd18;
    localparam logic [ST_W-1:0] ST_MULW   = 5'd19;
    localparam logic [ST_W-1:0] ST_DIVR   = 5'd20;

    localparam int W  = hcf_pkg::WORD_W;
    localparam int F  = hcf_pkg::FRAC_W;
    localparam int PW = hcf_pkg::PROD_W;
    localparam int DW = hcf_pkg::DIV_W;
    localparam int CW = hcf_pkg::CNT_W;

    logic [ST_W-1:0] r_state, n_state, r_ret, n_ret;
    hcf_pkg::t_word  r_max, n_max, r_zfo, n_zfo, r_prev, n_prev;
    hcf_pkg::t_word  r_d, n_d, r_v, n_v, r_k2, n_k2, r_k1e, n_k1e;
    hcf_pkg::t_word  r_x, n_x, r_t, n_t, r_l, n_l, r_a, n_a, r_fh, n_fh;
    logic            r_neg, n_neg, r_adh, n_adh, r_sat, n_sat;
    logic [W-1:0]    r_ma, n_ma, r_mb, n_mb;
    logic            r_mneg, n_mneg;
    logic [PW-1:0]   r_prod;
    logic [DW-1:0]   r_dq, n_dq;
    logic [W-1:0]    r_rem, n_rem, r_dvs, n_dvs;
    logic            r_dneg, n_dneg;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_ovalid, n_ovalid, r_oc, n_oc, r_os, n_os;
    hcf_pkg::t_word  r_of, n_of;

    hcf_pkg::t_word  k1, kp, kc, g0, dpm, dpn, k2c;
    hcf_pkg::t_sv    mul_r, div_r, s1;
    logic [DW-1:0]   div_m;
    logic [W:0]      rem_sh;
    logic            ge, out_free, sat_or, mreq, dreq;
    hcf_pkg::t_word  ma_in, mb_in, da_in, db_in;
    logic [ST_W-1:0] ret_in;

    assign k1  = hcf_pkg::f_ext(i_cfg.k1);
    assign kp  = hcf_pkg::f_ext(i_cfg.kp);
    assign kc  = hcf_pkg::f_ext(i_cfg.kc);
    assign g0  = hcf_pkg::f_ext(i_cfg.g0);
    assign dpm = hcf_pkg::f_ext(i_cfg.dpm);
    assign dpn = hcf_pkg::f_ext(i_cfg.dpn);

    assign mul_r    = hcf_pkg::f_clip(r_mneg, r_prod[PW-1:F]);
    assign div_m    = ((r_dvs == '0) && (r_dq != '0)) ? '1 : r_dq;
    assign div_r    = hcf_pkg::f_clip(r_dneg, div_m);
    assign rem_sh   = {r_rem, r_dq[DW-1]};
    assign ge       = (rem_sh >= {1'b0, r_dvs});
    assign out_free = !r_ovalid || i_ready;

    assign o_take         = (r_state == ST_IDLE) && i_valid;
    assign o_valid        = r_ovalid;
    assign o_in_contact   = r_oc;
    assign o_normal_force = r_of;
    assign o_saturated    = r_os;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;
        n_max = r_max;  n_zfo = r_zfo;  n_prev = r_prev;
        n_d = r_d;  n_v = r_v;  n_k2 = r_k2;  n_k1e = r_k1e;
        n_x = r_x;  n_t = r_t;  n_l = r_l;  n_a = r_a;  n_fh = r_fh;
        n_neg = r_neg;  n_adh = r_adh;  n_sat = r_sat;
        n_ma = r_ma;  n_mb = r_mb;  n_mneg = r_mneg;
        n_dq = r_dq;  n_rem = r_rem;  n_dvs = r_dvs;  n_dneg = r_dneg;  n_cnt = r_cnt;
        n_ovalid = r_ovalid;  n_oc = r_oc;  n_os = r_os;  n_of = r_of;
        mreq = 1'b0;  dreq = 1'b0;  sat_or = 1'b0;
        ma_in = '0;  mb_in = '0;  da_in = '0;  db_in = '0;  ret_in = ST_IDLE;
        s1 = '0;  k2c = '0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_d   = i_item.overlap;
                    n_v   = i_item.normal_velocity;
                    n_neg = i_item.neg;
                    n_sat = 1'b0;
                    if (i_item.new_contact) begin
                        n_max  = '0;
                        n_zfo  = '0;
                        n_prev = '0;
                    end
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (r_neg) begin
                    n_state = ST_NEG;
                end else if ((dpm == '0) || (r_max >= dpm)) begin
                    n_k2    = kp;
                    n_state = ST_K2D;
                end else begin
                    s1     = hcf_pkg::f_sub(kp, k1);
                    n_x    = s1.val;
                    sat_or = s1.sat;
                    dreq   = 1'b1;  da_in = r_max;  db_in = dpm;  ret_in = ST_K2B;
                end
            end
            ST_K2B: begin
                sat_or = div_r.sat;
                mreq   = 1'b1;  ma_in = r_x;  mb_in = div_r.val;  ret_in = ST_K2C;
            end
            ST_K2C: begin
                s1      = hcf_pkg::f_add(k1, mul_r.val);
                n_k2    = s1.val;
                sat_or  = mul_r.sat | s1.sat;
                n_state = ST_K2D;
            end
            ST_K2D: begin
                k2c     = (r_k2 > kp) ? kp : r_k2;
                n_k2    = k2c;
                n_k1e   = (k1 > k2c) ? k2c : k1;
                n_state = ST_NEWMAX;
            end
            ST_NEWMAX: begin
                if (r_d > r_max) begin
                    n_max   = r_d;
                    n_adh   = 1'b0;
                    n_state = ST_PN0;
                end else begin
                    n_state = ST_T0;
                end
            end
            ST_PN0: begin
                s1     = hcf_pkg::f_sub(r_k2, r_k1e);
                sat_or = s1.sat;
                dreq   = 1'b1;  da_in = s1.val;  db_in = r_k2;  ret_in = ST_PN1;
            end
            ST_PN1: begin
                sat_or = div_r.sat;
                mreq   = 1'b1;  ma_in = div_r.val;  mb_in = r_max;  ret_in = ST_PN2;
            end
            ST_PN2: begin
                sat_or  = mul_r.sat;
                n_zfo   = (mul_r.val < dpn) ? mul_r.val : dpn;
                n_state = r_adh ? ST_FIN : ST_T0;
            end
            ST_T0: begin
                s1     = hcf_pkg::f_sub(r_d, r_zfo);
                sat_or = s1.sat;
                mreq   = 1'b1;  ma_in = r_k2;  mb_in = s1.val;  ret_in = ST_T1;
            end
            ST_T1: begin
                n_t    = mul_r.val;
                sat_or = mul_r.sat;
                mreq   = 1'b1;  ma_in = r_k1e;  mb_in = r_d;  ret_in = ST_T2;
            end
            ST_T2: begin
                n_l    = mul_r.val;
                sat_or = mul_r.sat;
                mreq   = 1'b1;  ma_in = kc;  mb_in = r_d;  ret_in = ST_T3;
            end
            ST_T3: begin
                s1      = hcf_pkg::f_sub('0, mul_r.val);
                n_a     = s1.val;
                sat_or  = mul_r.sat | s1.sat;
                n_state = ST_BR;
            end
            ST_BR: begin
                priority if (r_t >= r_l) begin
                    n_fh    = (r_d < dpm) ? r_l : r_t;
                    n_state = ST_FIN;
                end else if (r_t > r_a) begin
                    n_fh    = r_t;
                    n_state = ST_FIN;
                end else if (r_d < r_prev) begin
                    n_fh   = r_a;
                    s1     = hcf_pkg::f_add(r_k2, kc);
                    sat_or = s1.sat;
                    mreq   = 1'b1;  ma_in = r_d;  mb_in = s1.val;  ret_in = ST_AD1;
                end else begin
                    n_fh    = r_t;
                    n_state = ST_FIN;
                end
            end
            ST_AD1: begin
                s1     = hcf_pkg::f_sub(r_k2, r_k1e);
                sat_or = mul_r.sat | s1.sat;
                dreq   = 1'b1;  da_in = mul_r.val;  db_in = s1.val;  ret_in = ST_AD2;
            end
            ST_AD2: begin
                n_max   = div_r.val;
                sat_or  = div_r.sat;
                n_adh   = 1'b1;
                n_state = ST_PN0;
            end
            ST_FIN: begin
                n_prev = r_d;
                mreq   = 1'b1;  ma_in = g0;  mb_in = r_v;  ret_in = ST_OUT;
            end
            ST_OUT: begin
                s1 = hcf_pkg::f_add(r_fh, mul_r.val);
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oc     = 1'b1;
                    n_of     = s1.val;
                    n_os     = r_sat | mul_r.sat | s1.sat;
                    n_state  = ST_IDLE;
                end
            end
            ST_NEG: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oc     = 1'b0;
                    n_of     = '0;
                    n_os     = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            ST_MULW: begin
                n_state = r_ret;
            end
            ST_DIVR: begin
                n_rem = ge ? W'(rem_sh - {1'b0, r_dvs}) : rem_sh[W-1:0];
                n_dq  = {r_dq[DW-2:0], ge};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_sat = n_sat | sat_or;
        if (mreq) begin
            n_ma    = hcf_pkg::f_mag(ma_in);
            n_mb    = hcf_pkg::f_mag(mb_in);
            n_mneg  = ma_in[W-1] ^ mb_in[W-1];
            n_ret   = ret_in;
            n_state = ST_MULW;
        end
        if (dreq) begin
            n_dq    = {hcf_pkg::f_mag(da_in), F'(0)};
            n_dvs   = hcf_pkg::f_mag(db_in);
            n_dneg  = da_in[W-1] ^ db_in[W-1];
            n_rem   = '0;
            n_cnt   = CW'(DW);
            n_ret   = ret_in;
            n_state = (db_in == '0) ? ret_in : ST_DIVR;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
        r_ret  <= n_ret;
        r_d <= n_d;  r_v <= n_v;  r_k2 <= n_k2;  r_k1e <= n_k1e;
        r_x <= n_x;  r_t <= n_t;  r_l <= n_l;  r_a <= n_a;  r_fh <= n_fh;
        r_neg <= n_neg;  r_adh <= n_adh;  r_sat <= n_sat;
        r_ma <= n_ma;  r_mb <= n_mb;  r_mneg <= n_mneg;
        r_dq <= n_dq;  r_rem <= n_rem;  r_dvs <= n_dvs;  r_dneg <= n_dneg;
        r_cnt <= n_cnt;
        r_oc <= n_oc;  r_os <= n_os;  r_of <= n_of;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_max    <= '0;
            r_zfo    <= '0;
            r_prev   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_max    <= n_max;
            r_zfo    <= n_zfo;
            r_prev   <= n_prev;
        end
    end
endmodule

// ===== rtl/hysteretic_contact_force_core.sv =====
// ----------------------------------------------------------------------------
// hysteretic_contact_force_core: adhesive elasto-plastic normal contact force
// Configuration registers, intake queue and force sequencer for one contact.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  i_in_ch    in   valid/ready   overlap, normal_velocity, new_contact
//  o_out_ch   out  valid/ready   in_contact, normal_force, saturated
//  i_cfg_*    in   write enable  i_cfg_idx, i_cfg_data
//
//  Negative overlap skips the contact law. A contact item runs up to four
//  divisions per item on the radix-2 divider.
//  The multiplier registers its operands, then the product; eight products at most.
//  The queue takes QUEUE_DEPTH items while the sequencer or the output stalls.
//  Synchronous reset clears history, queue and output valid; registers load
//  their defaults.
// ----------------------------------------------------------------------------
module hysteretic_contact_force_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hcf_in_if.sink                          i_in_ch,
    hcf_out_if.source                       o_out_ch,
    input  logic                            i_cfg_we,
    input  logic [hcf_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [hcf_pkg::CFG_W-1:0]       i_cfg_data
);
    hcf_pkg::t_cfg  r_cfg;
    hcf_pkg::t_item in_item, q_item;
    logic           q_valid, q_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k1  <= hcf_pkg::RST_LOADING_STIFFNESS;
            r_cfg.kp  <= hcf_pkg::RST_LIMIT_STIFFNESS;
            r_cfg.kc  <= hcf_pkg::RST_ADHESION_STIFFNESS;
            r_cfg.g0  <= hcf_pkg::RST_DAMPING_COEFFICIENT;
            r_cfg.dpm <= hcf_pkg::RST_PLASTIC_LIMIT_OVERLAP;
            r_cfg.dpn <= hcf_pkg::RST_PLASTIC_OVERLAP_CAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hcf_pkg::CFG_LOADING_STIFFNESS:     r_cfg.k1  <= i_cfg_data;
                hcf_pkg::CFG_LIMIT_STIFFNESS:       r_cfg.kp  <= i_cfg_data;
                hcf_pkg::CFG_ADHESION_STIFFNESS:    r_cfg.kc  <= i_cfg_data;
                hcf_pkg::CFG_DAMPING_COEFFICIENT:   r_cfg.g0  <= i_cfg_data;
                hcf_pkg::CFG_PLASTIC_LIMIT_OVERLAP: r_cfg.dpm <= i_cfg_data;
                hcf_pkg::CFG_PLASTIC_OVERLAP_CAP:   r_cfg.dpn <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_item.overlap         = i_in_ch.overlap;
        in_item.normal_velocity = i_in_ch.normal_velocity;
        in_item.new_contact     = i_in_ch.new_contact;
        in_item.neg             = 1'b0;
    end

    hcf_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_ch.valid),
        .o_ready (i_in_ch.ready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_take  (q_take)
    );

    hcf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_take         (q_take),
        .o_valid        (o_out_ch.valid),
        .i_ready        (o_out_ch.ready),
        .o_in_contact   (o_out_ch.in_contact),
        .o_normal_force (o_out_ch.normal_force),
        .o_saturated    (o_out_ch.saturated)
    );
endmodule

// ===== rtl/hcf_checker.sv =====
// ----------------------------------------------------------------------------
// hcf_checker: port-level checks for the contact core
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module hcf_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_out_in_contact,
    input hcf_pkg::t_word        i_out_normal_force,
    input logic                  i_out_saturated
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_normal_force)
        && $stable(i_out_in_contact) && $stable(i_out_saturated))
        else $error("result item changed while stalled");

    a_no_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_in_contact |-> (i_out_normal_force == '0)
        && !i_out_saturated)
        else $error("item without contact carries force or clip flag");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");
endmodule

bind hysteretic_contact_force_core hcf_checker u_hcf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out_ch.valid),
    .i_out_ready        (o_out_ch.ready),
    .i_out_in_contact   (o_out_ch.in_contact),
    .i_out_normal_force (o_out_ch.normal_force),
    .i_out_saturated    (o_out_ch.saturated)
);
